// ===== rtl/core/ehc_pkg.sv =====
package ehc_pkg;

	// Field widths
	localparam int unsigned TOTAL_W    = 32;
	localparam int unsigned OFF_W      = 7;
	localparam int unsigned LEN_W      = OFF_W + 1;
	localparam int unsigned FIFO_DEPTH = 2;

	// Frame layout offsets
	localparam logic [OFF_W-1:0] OFF_MAX        = 7'd127;
	localparam logic [OFF_W-1:0] ETH_TYPE_POS   = 7'd12;
	localparam logic [OFF_W-1:0] ETH_TYPE_POS_LO = 7'd13;
	localparam logic [OFF_W-1:0] ETH_HDR_LEN    = 7'd14;
	localparam logic [OFF_W-1:0] V4_PROTO_POS   = 7'd23;
	localparam logic [OFF_W-1:0] V4_SRC_FIRST   = 7'd26;
	localparam logic [OFF_W-1:0] V4_SRC_LAST    = 7'd29;
	localparam logic [OFF_W-1:0] V4_DST_FIRST   = 7'd30;
	localparam logic [OFF_W-1:0] V4_DST_LAST    = 7'd33;
	localparam logic [OFF_W-1:0] V6_NH_POS      = 7'd20;
	localparam logic [OFF_W-1:0] V6_SRC_HI_FIRST = 7'd22;
	localparam logic [OFF_W-1:0] V6_SRC_HI_LAST = 7'd29;
	localparam logic [OFF_W-1:0] V6_SRC_LO_FIRST = 7'd30;
	localparam logic [OFF_W-1:0] V6_SRC_LO_LAST = 7'd37;
	localparam logic [OFF_W-1:0] V6_DST_HI_FIRST = 7'd38;
	localparam logic [OFF_W-1:0] V6_DST_HI_LAST = 7'd45;
	localparam logic [OFF_W-1:0] V6_DST_LO_FIRST = 7'd46;
	localparam logic [OFF_W-1:0] V6_DST_LO_LAST = 7'd53;
	localparam logic [OFF_W-1:0] V6_SPORT_POS   = 7'd54;
	localparam logic [OFF_W-1:0] V6_DPORT_POS   = 7'd56;

	// Length thresholds
	localparam logic [LEN_W-1:0] ETH_MIN_LEN = 8'd14;
	localparam logic [LEN_W-1:0] V4_MIN_LEN  = 8'd34;
	localparam logic [LEN_W-1:0] V6_MIN_LEN  = 8'd54;
	localparam logic [LEN_W-1:0] TCP_HDR_LEN = 8'd20;
	localparam logic [LEN_W-1:0] UDP_HDR_LEN = 8'd8;

	// EtherTypes and protocol numbers
	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [15:0] ETHERTYPE_IPV6 = 16'h86DD;
	localparam logic [7:0]  PROTO_ICMP     = 8'd1;
	localparam logic [7:0]  PROTO_TCP      = 8'd6;
	localparam logic [7:0]  PROTO_UDP      = 8'd17;
	localparam logic [7:0]  PROTO_ICMPV6   = 8'd58;

	// Class codes
	localparam logic [3:0] CLASS_NONE     = 4'd0;
	localparam logic [3:0] CLASS_V4_TCP   = 4'd1;
	localparam logic [3:0] CLASS_V4_UDP   = 4'd2;
	localparam logic [3:0] CLASS_V4_ICMP  = 4'd3;
	localparam logic [3:0] CLASS_V4_OTHER = 4'd4;
	localparam logic [3:0] CLASS_V6_TCP   = 4'd5;
	localparam logic [3:0] CLASS_V6_UDP   = 4'd6;
	localparam logic [3:0] CLASS_V6_ICMP  = 4'd7;
	localparam logic [3:0] CLASS_V6_OTHER = 4'd8;

	// Counter indexes
	localparam int unsigned NUM_COUNTERS = 5;
	localparam int unsigned CNT_IPV4     = 0;
	localparam int unsigned CNT_IPV6     = 1;
	localparam int unsigned CNT_TCP      = 2;
	localparam int unsigned CNT_UDP      = 3;
	localparam int unsigned CNT_OTHER    = 4;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last_byte;
	} ehc_byte_t;

	typedef struct packed {
		logic [3:0]  frame_class;
		logic [15:0] src_port;
		logic [15:0] dest_port;
		logic [63:0] source_addr_high;
		logic [63:0] source_addr_low;
		logic [63:0] dest_addr_high;
		logic [63:0] dest_addr_low;
	} ehc_frame_rec_t;

	typedef struct packed {
		logic [3:0]         frame_class;
		logic [15:0]        src_port;
		logic [15:0]        dest_port;
		logic [63:0]        source_addr_high;
		logic [63:0]        source_addr_low;
		logic [63:0]        dest_addr_high;
		logic [63:0]        dest_addr_low;
		logic [TOTAL_W-1:0] ipv4_total;
		logic [TOTAL_W-1:0] ipv6_total;
		logic [TOTAL_W-1:0] tcp_total;
		logic [TOTAL_W-1:0] udp_total;
		logic [TOTAL_W-1:0] other_total;
	} ehc_result_t;

endpackage

// ===== rtl/core/ehc_stream_if.sv =====
interface ehc_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/ehc_parser.sv =====
module ehc_parser
	import ehc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	ehc_stream_if.sink   frame_in,
	ehc_stream_if.source rec_out
);

	logic [OFF_W-1:0] off_q;
	logic [15:0]      kind_q, kind_n;
	logic [3:0]       ihl_q, ihl_n;
	logic [7:0]       proto_q, proto_n;
	logic [63:0]      src_hi_q, src_hi_n, src_lo_q, src_lo_n;
	logic [63:0]      dst_hi_q, dst_hi_n, dst_lo_q, dst_lo_n;
	logic [15:0]      sport_q, sport_n, dport_q, dport_n;

	logic [7:0]       b;
	logic [3:0]       words;
	logic [OFF_W-1:0] base;
	logic [OFF_W-1:0] l4_v4;
	logic [LEN_W-1:0] len;
	logic [3:0]       cls;
	logic             ports_ok;
	logic             accept;
	ehc_frame_rec_t   rec;

	assign b      = frame_in.data.frame_byte;
	assign accept = frame_in.valid && frame_in.ready;

	// Stall input whenever the queue cannot take a record, also on bytes that are not final
	assign frame_in.ready = rec_out.ready;
	assign rec_out.valid  = frame_in.valid && frame_in.data.last_byte;
	assign rec_out.data   = rec;

	// Latch header fields from the current byte
	always_comb begin
		kind_n   = kind_q;
		ihl_n    = ihl_q;
		proto_n  = proto_q;
		src_hi_n = src_hi_q;
		src_lo_n = src_lo_q;
		dst_hi_n = dst_hi_q;
		dst_lo_n = dst_lo_q;
		sport_n  = sport_q;
		dport_n  = dport_q;
		words    = (off_q == ETH_HDR_LEN) ? b[3:0] : ihl_q;
		base     = ETH_HDR_LEN + {1'b0, words, 2'b00};
		if (off_q == ETH_TYPE_POS) begin
			kind_n[15:8] = b;
		end else if (off_q == ETH_TYPE_POS_LO) begin
			kind_n[7:0] = b;
		end else if (kind_q == ETHERTYPE_IPV4) begin
			if (off_q == ETH_HDR_LEN)
				ihl_n = b[3:0];
			if (off_q == V4_PROTO_POS)
				proto_n = b;
			if (off_q >= V4_SRC_FIRST && off_q <= V4_SRC_LAST)
				src_lo_n = {32'd0, src_lo_q[23:0], b};
			if (off_q >= V4_DST_FIRST && off_q <= V4_DST_LAST)
				dst_lo_n = {32'd0, dst_lo_q[23:0], b};
			if (off_q == base || off_q == base + 7'd1)
				sport_n = {sport_q[7:0], b};
			if (off_q == base + 7'd2 || off_q == base + 7'd3)
				dport_n = {dport_q[7:0], b};
		end else if (kind_q == ETHERTYPE_IPV6) begin
			if (off_q == V6_NH_POS)
				proto_n = b;
			else if (off_q >= V6_SRC_HI_FIRST && off_q <= V6_SRC_HI_LAST)
				src_hi_n = {src_hi_q[55:0], b};
			else if (off_q >= V6_SRC_LO_FIRST && off_q <= V6_SRC_LO_LAST)
				src_lo_n = {src_lo_q[55:0], b};
			else if (off_q >= V6_DST_HI_FIRST && off_q <= V6_DST_HI_LAST)
				dst_hi_n = {dst_hi_q[55:0], b};
			else if (off_q >= V6_DST_LO_FIRST && off_q <= V6_DST_LO_LAST)
				dst_lo_n = {dst_lo_q[55:0], b};
			else if (off_q == V6_SPORT_POS || off_q == V6_SPORT_POS + 7'd1)
				sport_n = {sport_q[7:0], b};
			else if (off_q == V6_DPORT_POS || off_q == V6_DPORT_POS + 7'd1)
				dport_n = {dport_q[7:0], b};
		end
	end

	// Classify the frame on its final byte, from the freshly latched fields
	assign len   = {1'b0, off_q} + 8'd1;
	assign l4_v4 = ETH_HDR_LEN + {1'b0, ihl_n, 2'b00};

	always_comb begin
		cls      = CLASS_NONE;
		ports_ok = 1'b0;
		if (len >= ETH_MIN_LEN && kind_n == ETHERTYPE_IPV4 && len >= V4_MIN_LEN) begin
			if (proto_n == PROTO_TCP) begin
				cls      = CLASS_V4_TCP;
				ports_ok = len >= {1'b0, l4_v4} + TCP_HDR_LEN;
			end else if (proto_n == PROTO_UDP) begin
				cls      = CLASS_V4_UDP;
				ports_ok = len >= {1'b0, l4_v4} + UDP_HDR_LEN;
			end else begin
				cls = (proto_n == PROTO_ICMP) ? CLASS_V4_ICMP : CLASS_V4_OTHER;
			end
		end else if (len >= ETH_MIN_LEN && kind_n == ETHERTYPE_IPV6 &&
				len >= V6_MIN_LEN) begin
			if (proto_n == PROTO_TCP) begin
				cls      = CLASS_V6_TCP;
				ports_ok = len >= V6_MIN_LEN + TCP_HDR_LEN;
			end else if (proto_n == PROTO_UDP) begin
				cls      = CLASS_V6_UDP;
				ports_ok = len >= V6_MIN_LEN + UDP_HDR_LEN;
			end else begin
				cls = (proto_n == PROTO_ICMPV6) ? CLASS_V6_ICMP : CLASS_V6_OTHER;
			end
		end
	end

	// Build the frame record, zeroing what does not apply
	always_comb begin
		rec                  = '0;
		rec.frame_class      = cls;
		if (cls != CLASS_NONE) begin
			if (ports_ok) begin
				rec.src_port  = sport_n;
				rec.dest_port = dport_n;
			end
			rec.source_addr_high = src_hi_n;
			rec.source_addr_low  = src_lo_n;
			rec.dest_addr_high   = dst_hi_n;
			rec.dest_addr_low    = dst_lo_n;
		end
	end

	// Advance the byte offset; clear per-frame state after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q    <= '0;
			kind_q   <= '0;
			ihl_q    <= '0;
			proto_q  <= '0;
			src_hi_q <= '0;
			src_lo_q <= '0;
			dst_hi_q <= '0;
			dst_lo_q <= '0;
			sport_q  <= '0;
			dport_q  <= '0;
		end else if (accept) begin
			if (frame_in.data.last_byte) begin
				off_q    <= '0;
				kind_q   <= '0;
				ihl_q    <= '0;
				proto_q  <= '0;
				src_hi_q <= '0;
				src_lo_q <= '0;
				dst_hi_q <= '0;
				dst_lo_q <= '0;
				sport_q  <= '0;
				dport_q  <= '0;
			end else begin
				if (off_q != OFF_MAX)
					off_q <= off_q + 7'd1;
				kind_q   <= kind_n;
				ihl_q    <= ihl_n;
				proto_q  <= proto_n;
				src_hi_q <= src_hi_n;
				src_lo_q <= src_lo_n;
				dst_hi_q <= dst_hi_n;
				dst_lo_q <= dst_lo_n;
				sport_q  <= sport_n;
				dport_q  <= dport_n;
			end
		end
	end

endmodule

// ===== rtl/core/ehc_rec_fifo.sv =====
module ehc_rec_fifo
	import ehc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	ehc_stream_if.sink   push,
	ehc_stream_if.source pop
);

	localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
	localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

	ehc_frame_rec_t   mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wptr_q, rptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign push.ready = (count_q != CNT_W'(FIFO_DEPTH));
	assign pop.valid  = (count_q != '0);
	assign pop.data   = mem_q[rptr_q];
	assign do_push    = push.valid && push.ready;
	assign do_pop     = pop.valid && pop.ready;

	// Store records on transfer in
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wptr_q] <= push.data;
	end

	// Track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push)
				wptr_q <= (wptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
			if (do_pop)
				rptr_q <= (rptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
			if (do_push && !do_pop)
				count_q <= count_q + CNT_W'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

// ===== rtl/core/ehc_counter_out.sv =====
module ehc_counter_out
	import ehc_pkg::*;
#(
	parameter int unsigned COUNTER_WIDTH = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	ehc_stream_if.sink   rec_in,
	ehc_stream_if.source result_out
);

	logic [COUNTER_WIDTH-1:0] cnt_q [NUM_COUNTERS];
	logic [TOTAL_W-1:0]       tot   [NUM_COUNTERS];
	logic [NUM_COUNTERS-1:0]  hit;
	ehc_frame_rec_t           rec_q;
	logic                     valid_q;
	logic                     take;
	logic [3:0]               c;

	// Accept a record while the output register is free or being drained
	assign rec_in.ready = !valid_q || result_out.ready;
	assign take         = rec_in.valid && rec_in.ready;
	assign c            = rec_in.data.frame_class;

	// Select the counters this frame bumps
	always_comb begin
		hit            = '0;
		hit[CNT_IPV4]  = (c >= CLASS_V4_TCP) && (c <= CLASS_V4_OTHER);
		hit[CNT_IPV6]  = (c >= CLASS_V6_TCP) && (c <= CLASS_V6_OTHER);
		hit[CNT_TCP]   = (c == CLASS_V4_TCP) || (c == CLASS_V6_TCP);
		hit[CNT_UDP]   = (c == CLASS_V4_UDP) || (c == CLASS_V6_UDP);
		hit[CNT_OTHER] = (c == CLASS_V4_ICMP) || (c == CLASS_V4_OTHER) ||
			(c == CLASS_V6_ICMP) || (c == CLASS_V6_OTHER);
	end

	// Saturating counters, each advanced on a record transfer that selects it
	for (genvar i = 0; i < NUM_COUNTERS; i++) begin : g_cnt
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				cnt_q[i] <= '0;
			else if (take && hit[i] && cnt_q[i] != '1)
				cnt_q[i] <= cnt_q[i] + COUNTER_WIDTH'(1);
		end

		if (COUNTER_WIDTH >= TOTAL_W) begin : g_trunc
			assign tot[i] = cnt_q[i][TOTAL_W-1:0];
		end else begin : g_ext
			assign tot[i] = {{(TOTAL_W - COUNTER_WIDTH){1'b0}}, cnt_q[i]};
		end
	end

	// Hold the result until transferred
	always_ff @(posedge clk) begin
		if (take)
			rec_q <= rec_in.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (take)
			valid_q <= 1'b1;
		else if (result_out.ready)
			valid_q <= 1'b0;
	end

	assign result_out.valid                 = valid_q;
	assign result_out.data.frame_class      = rec_q.frame_class;
	assign result_out.data.src_port         = rec_q.src_port;
	assign result_out.data.dest_port        = rec_q.dest_port;
	assign result_out.data.source_addr_high = rec_q.source_addr_high;
	assign result_out.data.source_addr_low  = rec_q.source_addr_low;
	assign result_out.data.dest_addr_high   = rec_q.dest_addr_high;
	assign result_out.data.dest_addr_low    = rec_q.dest_addr_low;
	assign result_out.data.ipv4_total       = tot[CNT_IPV4];
	assign result_out.data.ipv6_total       = tot[CNT_IPV6];
	assign result_out.data.tcp_total        = tot[CNT_TCP];
	assign result_out.data.udp_total        = tot[CNT_UDP];
	assign result_out.data.other_total      = tot[CNT_OTHER];

endmodule

// ===== rtl/core/ethernet_ip_header_classifier_unit.sv =====
// Takes one frame byte per cycle while the record queue has room, with no gaps between frames.
// After the final byte transfers in, its record is registered in the parser-to-counter
// record queue (two entries) and then in the output register, from which the result transfers out.
// Reset clears the byte offset, latched header fields, the queue and all counters;
// no clearing pass is needed, the block accepts bytes from the first cycle.
module ethernet_ip_header_classifier_unit
	import ehc_pkg::*;
#(
	parameter int unsigned COUNTER_WIDTH = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	ehc_stream_if.sink   frame_in,
	ehc_stream_if.source result_out
);

	ehc_stream_if #(.payload_t(ehc_frame_rec_t)) parse_rec ();
	ehc_stream_if #(.payload_t(ehc_frame_rec_t)) queued_rec ();

	ehc_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.frame_in (frame_in),
		.rec_out  (parse_rec.source)
	);

	ehc_rec_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (parse_rec.sink),
		.pop    (queued_rec.source)
	);

	ehc_counter_out #(
		.COUNTER_WIDTH (COUNTER_WIDTH)
	) u_counter_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.rec_in     (queued_rec.sink),
		.result_out (result_out)
	);

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import ehc_pkg::*;

	localparam int unsigned COUNTER_BITS = 32;
	localparam logic [63:0] COUNT_MAX = (COUNTER_BITS >= 64) ? '1 : ((64'd1 << COUNTER_BITS) - 1);
	localparam int unsigned IDLE_PCT = 38;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned RANDOM_FRAMES = 6;

	typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

	logic clk = 1'b0;
	logic arst_n;

	ehc_stream_if #(.payload_t(ehc_byte_t)) frame_in_if ();
	ehc_stream_if #(.payload_t(ehc_result_t)) result_if ();

	ethernet_ip_header_classifier_unit #(
		.COUNTER_WIDTH(COUNTER_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.frame_in(frame_in_if),
		.result_out(result_if)
	);

	// Parser copy: per-frame fields and running counters
	logic [6:0]  cur_pos;
	logic [15:0] cur_kind;
	logic [3:0]  cur_ihl;
	logic [7:0]  cur_proto;
	logic [63:0] cur_src_hi, cur_src_lo, cur_dst_hi, cur_dst_lo;
	logic [15:0] cur_sport, cur_dport;
	logic [63:0] proto_count [NUM_COUNTERS];

	ehc_result_t pending_verdicts [$];
	logic [7:0]  frame_buf [$];
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;
	bit          no_stall = 1'b0;

	always #10 clk = ~clk;

	// Give up on a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("ethernet_ip_header_classifier_unit regression: fail");
			$finish;
		end
	end

	// Stall the result side at random, except in the steady stretch
	always @(posedge clk) begin
		result_if.ready <= no_stall || ($urandom_range(99) >= IDLE_PCT);
	end

	task automatic flag_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("[%0t] mismatch on %s: got %h, want %h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	task automatic check_field(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			flag_mismatch(what, got, want);
	endtask

	function automatic void clear_frame_fields();
		cur_pos    = '0;
		cur_kind   = '0;
		cur_ihl    = '0;
		cur_proto  = '0;
		cur_src_hi = '0;
		cur_src_lo = '0;
		cur_dst_hi = '0;
		cur_dst_lo = '0;
		cur_sport  = '0;
		cur_dport  = '0;
	endfunction

	function automatic void bump_count(input int unsigned idx);
		if (proto_count[idx] < COUNT_MAX)
			proto_count[idx]++;
	endfunction

	function automatic void append_byte(input logic [7:0] v);
		frame_buf = {frame_buf, v};
	endfunction

	// Advance the parser copy by one byte; on the final byte queue the verdict
	task automatic absorb_byte(input logic [7:0] b, input logic last);
		int unsigned off, base, len, l4;
		logic [3:0]  words;
		logic [3:0]  cls;
		bit          ports_ok;
		ehc_result_t verdict;
		off = cur_pos;
		if (off == ETH_TYPE_POS) begin
			cur_kind[15:8] = b;
		end else if (off == ETH_TYPE_POS_LO) begin
			cur_kind[7:0] = b;
		end else if (cur_kind == ETHERTYPE_IPV4) begin
			// the L4 start follows the header-length nibble as given
			words = (off == ETH_HDR_LEN) ? b[3:0] : cur_ihl;
			base = int'(ETH_HDR_LEN) + 4 * int'(words);
			if (off == ETH_HDR_LEN)
				cur_ihl = b[3:0];
			if (off == V4_PROTO_POS)
				cur_proto = b;
			if (off >= V4_SRC_FIRST && off <= V4_SRC_LAST)
				cur_src_lo = {32'h0, cur_src_lo[23:0], b};
			if (off >= V4_DST_FIRST && off <= V4_DST_LAST)
				cur_dst_lo = {32'h0, cur_dst_lo[23:0], b};
			if (off == base || off == base + 1)
				cur_sport = {cur_sport[7:0], b};
			if (off == base + 2 || off == base + 3)
				cur_dport = {cur_dport[7:0], b};
		end else if (cur_kind == ETHERTYPE_IPV6) begin
			if (off == V6_NH_POS)
				cur_proto = b;
			else if (off >= V6_SRC_HI_FIRST && off <= V6_SRC_HI_LAST)
				cur_src_hi = {cur_src_hi[55:0], b};
			else if (off >= V6_SRC_LO_FIRST && off <= V6_SRC_LO_LAST)
				cur_src_lo = {cur_src_lo[55:0], b};
			else if (off >= V6_DST_HI_FIRST && off <= V6_DST_HI_LAST)
				cur_dst_hi = {cur_dst_hi[55:0], b};
			else if (off >= V6_DST_LO_FIRST && off <= V6_DST_LO_LAST)
				cur_dst_lo = {cur_dst_lo[55:0], b};
			else if (off == V6_SPORT_POS || off == V6_SPORT_POS + 1)
				cur_sport = {cur_sport[7:0], b};
			else if (off == V6_DPORT_POS || off == V6_DPORT_POS + 1)
				cur_dport = {cur_dport[7:0], b};
		end

		if (!last) begin
			if (cur_pos != OFF_MAX)
				cur_pos++;
			return;
		end

		// Classify the finished frame and update the counters
		len = off + 1;
		cls = CLASS_NONE;
		ports_ok = 1'b0;
		if (len >= ETH_MIN_LEN && cur_kind == ETHERTYPE_IPV4 && len >= V4_MIN_LEN) begin
			l4 = int'(ETH_HDR_LEN) + 4 * int'(cur_ihl);
			bump_count(CNT_IPV4);
			if (cur_proto == PROTO_TCP) begin
				cls = CLASS_V4_TCP;
				bump_count(CNT_TCP);
				ports_ok = len >= l4 + TCP_HDR_LEN;
			end else if (cur_proto == PROTO_UDP) begin
				cls = CLASS_V4_UDP;
				bump_count(CNT_UDP);
				ports_ok = len >= l4 + UDP_HDR_LEN;
			end else begin
				cls = (cur_proto == PROTO_ICMP) ? CLASS_V4_ICMP : CLASS_V4_OTHER;
				bump_count(CNT_OTHER);
			end
		end else if (len >= ETH_MIN_LEN && cur_kind == ETHERTYPE_IPV6
				&& len >= V6_MIN_LEN) begin
			l4 = int'(V6_MIN_LEN);
			bump_count(CNT_IPV6);
			if (cur_proto == PROTO_TCP) begin
				cls = CLASS_V6_TCP;
				bump_count(CNT_TCP);
				ports_ok = len >= l4 + TCP_HDR_LEN;
			end else if (cur_proto == PROTO_UDP) begin
				cls = CLASS_V6_UDP;
				bump_count(CNT_UDP);
				ports_ok = len >= l4 + UDP_HDR_LEN;
			end else begin
				cls = (cur_proto == PROTO_ICMPV6) ? CLASS_V6_ICMP : CLASS_V6_OTHER;
				bump_count(CNT_OTHER);
			end
		end

		verdict = '0;
		verdict.frame_class = cls;
		if (cls != CLASS_NONE) begin
			if (ports_ok) begin
				verdict.src_port  = cur_sport;
				verdict.dest_port = cur_dport;
			end
			verdict.source_addr_high = cur_src_hi;
			verdict.source_addr_low  = cur_src_lo;
			verdict.dest_addr_high   = cur_dst_hi;
			verdict.dest_addr_low    = cur_dst_lo;
		end
		verdict.ipv4_total  = proto_count[CNT_IPV4][TOTAL_W-1:0];
		verdict.ipv6_total  = proto_count[CNT_IPV6][TOTAL_W-1:0];
		verdict.tcp_total   = proto_count[CNT_TCP][TOTAL_W-1:0];
		verdict.udp_total   = proto_count[CNT_UDP][TOTAL_W-1:0];
		verdict.other_total = proto_count[CNT_OTHER][TOTAL_W-1:0];
		pending_verdicts = {pending_verdicts, verdict};
		clear_frame_fields();
	endtask

	// Compare each result transfer with the oldest verdict; sampled mid-cycle
	always @(negedge clk) begin
		ehc_result_t got, want;
		if (arst_n && result_if.valid && result_if.ready) begin
			got = result_if.data;
			if (pending_verdicts.size() == 0) begin
				flag_mismatch("unexpected result", 64'(got.frame_class), '0);
			end else begin
				want = pending_verdicts.pop_front();
				check_field("frame_class", 64'(got.frame_class), 64'(want.frame_class));
				check_field("src_port", 64'(got.src_port), 64'(want.src_port));
				check_field("dest_port", 64'(got.dest_port), 64'(want.dest_port));
				check_field("source_addr_high", got.source_addr_high, want.source_addr_high);
				check_field("source_addr_low", got.source_addr_low, want.source_addr_low);
				check_field("dest_addr_high", got.dest_addr_high, want.dest_addr_high);
				check_field("dest_addr_low", got.dest_addr_low, want.dest_addr_low);
				check_field("ipv4_total", 64'(got.ipv4_total), 64'(want.ipv4_total));
				check_field("ipv6_total", 64'(got.ipv6_total), 64'(want.ipv6_total));
				check_field("tcp_total", 64'(got.tcp_total), 64'(want.tcp_total));
				check_field("udp_total", 64'(got.udp_total), 64'(want.udp_total));
				check_field("other_total", 64'(got.other_total), 64'(want.other_total));
			end
		end
	end

	// Drive one byte, holding it until the transfer; called at a rising edge
	task automatic send_byte(input logic [7:0] b, input logic last);
		ehc_byte_t item;
		bit taken;
		if (!no_stall) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				frame_in_if.valid <= 1'b0;
				@(posedge clk);
			end
		end
		item.frame_byte = b;
		item.last_byte = last;
		frame_in_if.valid <= 1'b1;
		frame_in_if.data <= item;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = frame_in_if.ready;
			@(posedge clk);
		end
		absorb_byte(b, last);
	endtask

	task automatic send_frame();
		foreach (frame_buf[i])
			send_byte(frame_buf[i], i == frame_buf.size() - 1);
	endtask

	// Fill the frame buffer and place the EtherType and IP header fields
	task automatic make_frame(input int unsigned len, input logic [15:0] kind,
			input logic [3:0] ihl, input logic [7:0] proto, input fill_t fill);
		frame_buf.delete();
		for (int unsigned i = 0; i < len; i++) begin
			case (fill)
				FILL_ZERO: append_byte(8'h00);
				FILL_ONES: append_byte(8'hFF);
				default:   append_byte(8'($urandom));
			endcase
		end
		if (len > ETH_TYPE_POS)
			frame_buf[ETH_TYPE_POS] = kind[15:8];
		if (len > ETH_TYPE_POS_LO)
			frame_buf[ETH_TYPE_POS_LO] = kind[7:0];
		if (kind == ETHERTYPE_IPV4) begin
			if (len > ETH_HDR_LEN)
				frame_buf[ETH_HDR_LEN] = {4'h4, ihl};
			if (len > V4_PROTO_POS)
				frame_buf[V4_PROTO_POS] = proto;
		end else if (kind == ETHERTYPE_IPV6) begin
			if (len > ETH_HDR_LEN)
				frame_buf[ETH_HDR_LEN][7:4] = 4'h6;
			if (len > V6_NH_POS)
				frame_buf[V6_NH_POS] = proto;
		end
	endtask

	task automatic push_frame(input int unsigned len, input logic [15:0] kind,
			input logic [3:0] ihl, input logic [7:0] proto, input fill_t fill);
		make_frame(len, kind, ihl, proto, fill);
		send_frame();
	endtask

	task automatic test_short_and_non_ip();
		push_frame(1, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, FILL_RANDOM);
		push_frame(13, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, FILL_RANDOM);
		push_frame(14, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, FILL_RANDOM);
		push_frame(33, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, FILL_RANDOM);
		push_frame(53, ETHERTYPE_IPV6, 4'd0, PROTO_UDP, FILL_RANDOM);
		push_frame(60, 16'h0806, 4'd5, PROTO_TCP, FILL_RANDOM);
		// byte-swapped IPv4 EtherType is not IP
		push_frame(60, 16'h0008, 4'd5, PROTO_TCP, FILL_RANDOM);
	endtask

	task automatic test_ipv4_classes();
		push_frame(54, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, FILL_RANDOM);
		push_frame(53, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, FILL_RANDOM);
		push_frame(42, ETHERTYPE_IPV4, 4'd5, PROTO_UDP, FILL_RANDOM);
		push_frame(41, ETHERTYPE_IPV4, 4'd5, PROTO_UDP, FILL_RANDOM);
		push_frame(34, ETHERTYPE_IPV4, 4'd5, PROTO_ICMP, FILL_RANDOM);
		push_frame(60, ETHERTYPE_IPV4, 4'd5, 8'hFF, FILL_RANDOM);
	endtask

	// Header-length nibble taken as given: ports may overlap the IP header
	task automatic test_ipv4_header_length();
		push_frame(40, ETHERTYPE_IPV4, 4'd0, PROTO_TCP, FILL_RANDOM);
		push_frame(40, ETHERTYPE_IPV4, 4'd3, PROTO_UDP, FILL_RANDOM);
		push_frame(94, ETHERTYPE_IPV4, 4'd15, PROTO_TCP, FILL_RANDOM);
		push_frame(93, ETHERTYPE_IPV4, 4'd15, PROTO_TCP, FILL_RANDOM);
	endtask

	task automatic test_ipv6_classes();
		push_frame(74, ETHERTYPE_IPV6, 4'd0, PROTO_TCP, FILL_RANDOM);
		push_frame(73, ETHERTYPE_IPV6, 4'd0, PROTO_TCP, FILL_RANDOM);
		push_frame(62, ETHERTYPE_IPV6, 4'd0, PROTO_UDP, FILL_RANDOM);
		push_frame(61, ETHERTYPE_IPV6, 4'd0, PROTO_UDP, FILL_RANDOM);
		push_frame(54, ETHERTYPE_IPV6, 4'd0, PROTO_ICMPV6, FILL_RANDOM);
		push_frame(70, ETHERTYPE_IPV6, 4'd0, PROTO_ICMP, FILL_RANDOM);
	endtask

	// All-ones and all-zero content, and frames past the offset ceiling
	task automatic test_long_and_extreme();
		push_frame(140, ETHERTYPE_IPV4, 4'd15, PROTO_UDP, FILL_ONES);
		push_frame(130, ETHERTYPE_IPV6, 4'd0, PROTO_TCP, FILL_ZERO);
		push_frame(128, ETHERTYPE_IPV6, 4'd0, PROTO_TCP, FILL_ONES);
	endtask

	function automatic logic [7:0] pick_proto(input bit v6);
		case ($urandom_range(9))
			0, 1, 2, 3: return PROTO_TCP;
			4, 5, 6:    return PROTO_UDP;
			7:          return v6 ? PROTO_ICMPV6 : PROTO_ICMP;
			8:          return v6 ? PROTO_ICMP : PROTO_ICMPV6;
			default:    return 8'($urandom);
		endcase
	endfunction

	// Mostly well-formed IP frames, with truncated, long and non-IP ones mixed in
	task automatic make_random_frame();
		int unsigned pick, len, l4, full;
		logic [3:0]  ihl;
		logic [7:0]  proto;
		logic [15:0] kind;
		fill_t       fill;
		pick = $urandom_range(99);
		fill = ($urandom_range(19) == 0) ? FILL_ZERO :
			($urandom_range(19) == 0) ? FILL_ONES : FILL_RANDOM;
		ihl = ($urandom_range(3) == 0) ? 4'($urandom) : 4'd5;
		if (pick < 80) begin
			kind = (pick < 45) ? ETHERTYPE_IPV4 : ETHERTYPE_IPV6;
			proto = pick_proto(kind == ETHERTYPE_IPV6);
			l4 = (kind == ETHERTYPE_IPV4) ? int'(ETH_HDR_LEN) + 4 * int'(ihl) :
				int'(V6_MIN_LEN);
			full = l4 + ((proto == PROTO_TCP) ? TCP_HDR_LEN : UDP_HDR_LEN)
				+ $urandom_range(20);
			len = full;
			if ($urandom_range(7) == 0)
				len = $urandom_range(full, 1);
			else if ($urandom_range(19) == 0)
				len = $urandom_range(150, 120);
		end else if (pick < 90) begin
			kind = 16'($urandom);
			proto = 8'($urandom);
			len = $urandom_range(80, 14);
		end else begin
			kind = $urandom_range(1) ? ETHERTYPE_IPV4 : ETHERTYPE_IPV6;
			proto = pick_proto(kind == ETHERTYPE_IPV6);
			len = $urandom_range(V6_MIN_LEN - 1, 1);
		end
		make_frame(len, kind, ihl, proto, fill);
	endtask

	task automatic test_random_traffic();
		int unsigned frames;
		frames = 0;
		while (frames < RANDOM_FRAMES) begin
			// hold a stretch with no idling on either side
			no_stall = (frames >= 1 && frames < 5);
			make_random_frame();
			send_frame();
			frames++;
		end
		no_stall = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		frame_in_if.valid = 1'b0;
		frame_in_if.data = '0;
		result_if.ready = 1'b0;
		clear_frame_fields();
		foreach (proto_count[i])
			proto_count[i] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_short_and_non_ip();
		test_ipv4_classes();
		test_ipv4_header_length();
		test_ipv6_classes();
		test_long_and_extreme();
		test_random_traffic();
		frame_in_if.valid <= 1'b0;

		// drain, then allow for the output latency
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("ethernet_ip_header_classifier_unit regression: pass");
		else
			$display("ethernet_ip_header_classifier_unit regression: fail");
		$finish;
	end

endmodule
